// ===== design/salc_pkg.sv =====
// ----------------------------------------------------------------------------
// salc_pkg
// Shared types and constants of the set-associative LRU cache tag model.
// ----------------------------------------------------------------------------
package salc_pkg;

  localparam int SET_BITS_DEF = 6;
  localparam int WAYS_DEF     = 8;

  localparam int ADDR_W    = 32;
  localparam int OFFSET_W  = 5;
  localparam int COUNT_W   = 64;
  localparam int OUT_WAY_W = 3;

  localparam logic [OFFSET_W-1:0] OFFSET_RESET = 5'd6;

  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_t;

endpackage

// ===== design/set_associative_lru_cache.sv =====
// ----------------------------------------------------------------------------
// set_associative_lru_cache
// Tag-only set-associative cache with true LRU replacement and access counters.
// ----------------------------------------------------------------------------
// Channel   Ports                                   Handshake
// input     in_kind, in_address                     start && !busy
// result    out_hit, out_way, out_reads_seen,       out_strobe, one cycle
//           out_read_hits, out_writes_seen,
//           out_write_hits
// config    cfg_wdata                               cfg_we, no wait
//
// An access reads the set row (tags, valid bits, LRU order) from the row RAM
// when it is accepted and writes it back in the lookup state, so busy is high
// in the lookup state after each accepted transaction. The result appears with
// out_strobe in the cycle after write-back, alongside the next accept.
// After reset a clearing pass writes every set row with busy high;
// configuration writes are taken during it.
// ----------------------------------------------------------------------------
module set_associative_lru_cache #(
  parameter int SET_BITS = salc_pkg::SET_BITS_DEF,
  parameter int WAYS     = salc_pkg::WAYS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_kind,
  input  logic [salc_pkg::ADDR_W-1:0]   in_address,
  output logic                          out_strobe,
  output logic                          out_hit,
  output logic [salc_pkg::OUT_WAY_W-1:0] out_way,
  output logic [salc_pkg::COUNT_W-1:0]  out_reads_seen,
  output logic [salc_pkg::COUNT_W-1:0]  out_read_hits,
  output logic [salc_pkg::COUNT_W-1:0]  out_writes_seen,
  output logic [salc_pkg::COUNT_W-1:0]  out_write_hits,
  input  logic                          cfg_we,
  input  logic [salc_pkg::OFFSET_W-1:0] cfg_wdata
);

  localparam int NUM_SETS = 1 << SET_BITS;
  localparam int IDX_W    = (SET_BITS > 0) ? SET_BITS : 1;
  localparam int TAG_W    = salc_pkg::ADDR_W - SET_BITS;
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int TAGS_W   = WAYS * TAG_W;
  localparam int LRU_W    = WAYS * WAY_W;
  localparam int ROW_W    = TAGS_W + WAYS + LRU_W;

  salc_pkg::state_t state_r, state_nxt;

  logic [salc_pkg::OFFSET_W-1:0] offset_r;
  logic [IDX_W-1:0]              clr_cnt_r;
  logic                          kind_r;
  logic [TAG_W-1:0]              tag_r;
  logic [IDX_W-1:0]              set_r;

  logic                          strobe_r;
  logic                          hit_r;
  logic [salc_pkg::OUT_WAY_W-1:0] way_r;
  logic [salc_pkg::COUNT_W-1:0]  rd_cnt_r, rd_hit_r, wr_cnt_r, wr_hit_r;

  logic             accept;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [ROW_W-1:0] ram_wdata;
  logic [ROW_W-1:0] ram_rdata;
  logic [IDX_W-1:0] in_set;
  logic [TAG_W-1:0] in_tag;
  logic [salc_pkg::ADDR_W-1:0] shifted;

  logic [ROW_W-1:0] clear_row;
  logic [ROW_W-1:0] new_row;
  logic             lk_hit;
  logic [WAY_W-1:0] lk_way;
  logic [31:0]      lk_way_ext;

  assign busy   = (state_r != salc_pkg::ST_IDLE);
  assign accept = start && !busy;

  // Bits shifted past bit 31 are gone, so a large offset yields a zero tag.
  assign shifted = in_address >> offset_r;
  assign in_set  = (SET_BITS > 0) ? shifted[IDX_W-1:0] : '0;
  assign in_tag  = TAG_W'(shifted >> SET_BITS);

  salc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_SETS)
  ) u_row_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (in_set),
    .rdata (ram_rdata)
  );

  always_comb begin
    clear_row = '0;
    for (int i = 0; i < WAYS; i++) begin
      clear_row[TAGS_W + WAYS + i*WAY_W +: WAY_W] = WAY_W'(i);
    end
  end

  // Tag match, victim choice and LRU reorder for the row that was read.
  always_comb begin
    logic [TAG_W-1:0] tags  [WAYS];
    logic [WAYS-1:0]  valid;
    logic [WAY_W-1:0] lru   [WAYS];
    logic [WAY_W-1:0] lru_n [WAYS];
    logic [WAYS-1:0]  at_or_after;
    logic             seen;

    valid = ram_rdata[TAGS_W +: WAYS];
    for (int i = 0; i < WAYS; i++) begin
      tags[i] = ram_rdata[i*TAG_W +: TAG_W];
      lru[i]  = ram_rdata[TAGS_W + WAYS + i*WAY_W +: WAY_W];
    end

    lk_hit = 1'b0;
    lk_way = lru[0];
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (valid[i] && (tags[i] == tag_r)) begin
        lk_hit = 1'b1;
        lk_way = WAY_W'(i);
      end
    end

    // Everything from the chosen way's position upward moves down one slot.
    seen = 1'b0;
    for (int i = 0; i < WAYS; i++) begin
      seen           = seen | (lru[i] == lk_way);
      at_or_after[i] = seen;
    end
    for (int i = 0; i < WAYS - 1; i++) begin
      lru_n[i] = at_or_after[i] ? lru[i+1] : lru[i];
    end
    lru_n[WAYS-1] = lk_way;

    new_row = ram_rdata;
    if (!lk_hit) begin
      for (int i = 0; i < WAYS; i++) begin
        if (lk_way == WAY_W'(i)) begin
          new_row[i*TAG_W +: TAG_W] = tag_r;
          new_row[TAGS_W + i]       = 1'b1;
        end
      end
    end
    for (int i = 0; i < WAYS; i++) begin
      new_row[TAGS_W + WAYS + i*WAY_W +: WAY_W] = lru_n[i];
    end
  end

  assign lk_way_ext = 32'(lk_way);

  always_comb begin
    state_nxt = state_r;
    ram_we    = 1'b0;
    ram_waddr = set_r;
    ram_wdata = new_row;
    case (state_r)
      salc_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
        ram_wdata = clear_row;
        if (clr_cnt_r == IDX_W'(NUM_SETS - 1)) begin
          state_nxt = salc_pkg::ST_IDLE;
        end
      end
      salc_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = salc_pkg::ST_LOOKUP;
        end
      end
      salc_pkg::ST_LOOKUP: begin
        ram_we    = 1'b1;
        state_nxt = salc_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = salc_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= salc_pkg::ST_CLEAR;
      clr_cnt_r <= '0;
      offset_r  <= salc_pkg::OFFSET_RESET;
      strobe_r  <= 1'b0;
      rd_cnt_r  <= '0;
      rd_hit_r  <= '0;
      wr_cnt_r  <= '0;
      wr_hit_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= (state_r == salc_pkg::ST_LOOKUP);
      if (state_r == salc_pkg::ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (cfg_we) begin
        offset_r <= cfg_wdata;
      end
      if (state_r == salc_pkg::ST_LOOKUP) begin
        if (kind_r == salc_pkg::KIND_WRITE) begin
          wr_cnt_r <= wr_cnt_r + 1'b1;
          if (lk_hit) begin
            wr_hit_r <= wr_hit_r + 1'b1;
          end
        end else begin
          rd_cnt_r <= rd_cnt_r + 1'b1;
          if (lk_hit) begin
            rd_hit_r <= rd_hit_r + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= in_kind;
      tag_r  <= in_tag;
      set_r  <= in_set;
    end
    if (state_r == salc_pkg::ST_LOOKUP) begin
      hit_r <= lk_hit;
      way_r <= lk_way_ext[salc_pkg::OUT_WAY_W-1:0];
    end
  end

  assign out_strobe      = strobe_r;
  assign out_hit         = hit_r;
  assign out_way         = way_r;
  assign out_reads_seen  = rd_cnt_r;
  assign out_read_hits   = rd_hit_r;
  assign out_writes_seen = wr_cnt_r;
  assign out_write_hits  = wr_hit_r;

endmodule

// ===== design/salc_ram.sv =====
// ----------------------------------------------------------------------------
// salc_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== tb/set_associative_lru_cache_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// set_associative_lru_cache_test
// Drives read and write accesses into the LRU cache tag model under several
// block-size settings and checks every result against a behavioral copy of
// the tag store, valid bits, LRU order and access counters.
// ----------------------------------------------------------------------------
module set_associative_lru_cache_test;

  localparam int SET_BITS  = salc_pkg::SET_BITS_DEF;
  localparam int WAYS      = salc_pkg::WAYS_DEF;
  localparam int ADDR_W    = salc_pkg::ADDR_W;
  localparam int OFFSET_W  = salc_pkg::OFFSET_W;
  localparam int COUNT_W   = salc_pkg::COUNT_W;
  localparam int OUT_WAY_W = salc_pkg::OUT_WAY_W;
  localparam int NUM_SETS = 1 << SET_BITS;
  localparam int DRAIN    = 4;
  localparam int PHASES   = 8;
  localparam int PHASE_LEN = 100;

  typedef enum logic [1:0] {
    ACT_ACCESS,
    ACT_CONFIG,
    ACT_PAUSE
  } step_kind_t;

  typedef struct {
    step_kind_t          act;
    logic                kind;
    logic [ADDR_W-1:0]   addr;
    logic [OFFSET_W-1:0] offset;
    int                  idle_pct;
  } pending_step_t;

  typedef struct {
    logic                 hit;
    logic [OUT_WAY_W-1:0] way;
    logic [COUNT_W-1:0]   reads;
    logic [COUNT_W-1:0]   read_hits;
    logic [COUNT_W-1:0]   writes;
    logic [COUNT_W-1:0]   write_hits;
  } access_result_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  logic                          in_kind = salc_pkg::KIND_READ;
  logic [ADDR_W-1:0]             in_address = '0;
  logic                          out_strobe;
  logic                          out_hit;
  logic [OUT_WAY_W-1:0]          out_way;
  logic [COUNT_W-1:0]            out_reads_seen;
  logic [COUNT_W-1:0]            out_read_hits;
  logic [COUNT_W-1:0]            out_writes_seen;
  logic [COUNT_W-1:0]            out_write_hits;
  logic                          cfg_we = 1'b0;
  logic [OFFSET_W-1:0]           cfg_wdata = '0;

  // Shadow copy of the cache state.
  logic [31:0]          line_tag   [NUM_SETS][WAYS];
  logic                 line_valid [NUM_SETS][WAYS];
  logic [OUT_WAY_W-1:0] recency    [NUM_SETS][WAYS];
  logic [COUNT_W-1:0]   read_total, read_hit_total, write_total, write_hit_total;
  logic [OFFSET_W-1:0]  block_offset;

  pending_step_t  stimulus_q[$];
  access_result_t expected_results[$];
  int             quiet_cycles = 0;
  int             error_count = 0;

  set_associative_lru_cache uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_kind        (in_kind),
    .in_address     (in_address),
    .out_strobe     (out_strobe),
    .out_hit        (out_hit),
    .out_way        (out_way),
    .out_reads_seen (out_reads_seen),
    .out_read_hits  (out_read_hits),
    .out_writes_seen(out_writes_seen),
    .out_write_hits (out_write_hits),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void clear_shadow();
    for (int s = 0; s < NUM_SETS; s++) begin
      for (int w = 0; w < WAYS; w++) begin
        line_tag[s][w]   = '0;
        line_valid[s][w] = 1'b0;
        recency[s][w]    = OUT_WAY_W'(w);
      end
    end
    read_total      = '0;
    read_hit_total  = '0;
    write_total     = '0;
    write_hit_total = '0;
    block_offset    = salc_pkg::OFFSET_RESET;
  endfunction

  function automatic void cache_lookup(input logic kind, input logic [ADDR_W-1:0] addr,
                                       output access_result_t r);
    logic [63:0] wide;
    int          set_idx;
    logic [31:0] tag;
    int          way;
    logic        hit;
    logic        found;
    wide    = {32'b0, addr};
    set_idx = int'((wide >> block_offset) & 64'(NUM_SETS - 1));
    // Offsets near 31 shift every address bit out, leaving a zero tag.
    tag     = 32'(wide >> (int'(block_offset) + SET_BITS));
    hit     = 1'b0;
    way     = 0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (line_valid[set_idx][w] && line_tag[set_idx][w] == tag) begin
        hit = 1'b1;
        way = w;
      end
    end
    if (!hit) begin
      way = int'(recency[set_idx][0]) % WAYS;
      line_tag[set_idx][way]   = tag;
      line_valid[set_idx][way] = 1'b1;
    end
    found = 1'b0;
    for (int i = 0; i < WAYS; i++) begin
      if (int'(recency[set_idx][i]) == way) found = 1'b1;
      if (found && i < WAYS - 1) recency[set_idx][i] = recency[set_idx][i + 1];
    end
    recency[set_idx][WAYS - 1] = OUT_WAY_W'(way);
    if (kind == salc_pkg::KIND_WRITE) begin
      write_total++;
      if (hit) write_hit_total++;
    end else begin
      read_total++;
      if (hit) read_hit_total++;
    end
    r.hit        = hit;
    r.way        = OUT_WAY_W'(way);
    r.reads      = read_total;
    r.read_hits  = read_hit_total;
    r.writes     = write_total;
    r.write_hits = write_hit_total;
  endfunction

  task automatic add_access(input logic kind, input logic [ADDR_W-1:0] addr, input int pct);
    pending_step_t s;
    s.act      = ACT_ACCESS;
    s.kind     = kind;
    s.addr     = addr;
    s.offset   = '0;
    s.idle_pct = pct;
    stimulus_q.push_back(s);
  endtask

  task automatic add_control(input step_kind_t act, input logic [OFFSET_W-1:0] offset);
    pending_step_t s;
    s.act      = act;
    s.kind     = salc_pkg::KIND_READ;
    s.addr     = '0;
    s.offset   = offset;
    s.idle_pct = 0;
    stimulus_q.push_back(s);
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      error_count++;
      if (error_count <= 10)
        $display("%0t mismatch on %s: expected %0h, got %0h", $realtime, name, want, got);
    end
  endtask

  // Driver: presents the queued transactions and configuration writes.
  always @(posedge clk) begin
    logic           next_start;
    logic           next_we;
    logic           settled;
    access_result_t predicted;
    if (!rst_n) begin
      clear_shadow();
      start  <= 1'b0;
      cfg_we <= 1'b0;
    end else begin
      if (cfg_we) block_offset = cfg_wdata;
      if (start && !busy) begin
        cache_lookup(in_kind, in_address, predicted);
        expected_results.push_back(predicted);
      end
      next_start = start && busy;
      next_we    = 1'b0;
      settled    = quiet_cycles >= DRAIN && expected_results.size() == 0;
      if (!next_start && stimulus_q.size() > 0) begin
        case (stimulus_q[0].act)
          ACT_ACCESS: begin
            if ($urandom_range(99) >= stimulus_q[0].idle_pct) begin
              in_kind    <= stimulus_q[0].kind;
              in_address <= stimulus_q[0].addr;
              next_start = 1'b1;
              void'(stimulus_q.pop_front());
            end
          end
          ACT_CONFIG: begin
            if (settled) begin
              cfg_wdata <= stimulus_q[0].offset;
              next_we = 1'b1;
              void'(stimulus_q.pop_front());
            end
          end
          default: begin
            if (settled) void'(stimulus_q.pop_front());
          end
        endcase
      end
      start  <= next_start;
      cfg_we <= next_we;
    end
  end

  // Monitor: checks each result against the oldest prediction.
  always @(posedge clk) begin
    access_result_t want;
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else begin
      if (busy || out_strobe || start)
        quiet_cycles <= 0;
      else if (quiet_cycles < 1000)
        quiet_cycles <= quiet_cycles + 1;
      if (out_strobe) begin
        if (expected_results.size() == 0) begin
          error_count++;
          if (error_count <= 10) $display("%0t result with no transaction pending", $realtime);
        end else begin
          want = expected_results.pop_front();
          check_field("hit", 64'(want.hit), 64'(out_hit));
          check_field("way", 64'(want.way), 64'(out_way));
          check_field("reads_seen", want.reads, out_reads_seen);
          check_field("read_hits", want.read_hits, out_read_hits);
          check_field("writes_seen", want.writes, out_writes_seen);
          check_field("write_hits", want.write_hits, out_write_hits);
        end
      end
    end
  end

  initial begin
    logic [OFFSET_W-1:0] phase_offsets [PHASES];
    logic [31:0]         tag_pool [10];
    logic [63:0]         wide;
    logic [ADDR_W-1:0]   addr;
    int                  pct;
    int                  set_base;
    int                  off;

    phase_offsets = '{5'd16, 5'd0, 5'd31, 5'd6, 5'd3, 5'd26, 5'd12, 5'd9};

    // Directed accesses at the reset block size: set index is bits 11:6.
    add_access(salc_pkg::KIND_READ, 32'h0000_0000, 15);
    add_access(salc_pkg::KIND_WRITE, 32'h0000_0000, 15);
    add_access(salc_pkg::KIND_READ, 32'hFFFF_FFFF, 15);
    add_access(salc_pkg::KIND_WRITE, 32'hFFFF_FFFF, 15);
    // Nine distinct tags in one set overflow its eight ways.
    for (int t = 0; t < 9; t++)
      add_access(t[0], ADDR_W'((t << 12) | (5 << 6) | t), 15);
    add_access(salc_pkg::KIND_READ, ADDR_W'((3 << 12) | (5 << 6)), 15);
    add_access(salc_pkg::KIND_WRITE, ADDR_W'(5 << 6), 15);
    add_access(salc_pkg::KIND_WRITE, 32'h8000_0FC0, 15);
    // Large offsets leave the index or the tag, or both, at zero.
    add_control(ACT_CONFIG, 5'd31);
    add_access(salc_pkg::KIND_READ, 32'h7FFF_FFFF, 15);
    add_access(salc_pkg::KIND_WRITE, 32'h0000_0000, 15);
    add_control(ACT_CONFIG, 5'd26);
    add_access(salc_pkg::KIND_READ, 32'hFFFF_FFFF, 15);
    add_access(salc_pkg::KIND_WRITE, 32'h0400_0000, 15);
    add_control(ACT_CONFIG, 5'd0);
    add_access(salc_pkg::KIND_READ, 32'h1234_5678, 15);
    add_access(salc_pkg::KIND_WRITE, 32'h1234_5678, 15);

    // Random phases: a small working set of tags over a few adjacent sets
    // keeps hits, fills and evictions all frequent.
    for (int p = 0; p < PHASES; p++) begin
      pct = (p < 3) ? 15 : (p < 6) ? 67 : 0;
      off = int'(phase_offsets[p]);
      add_control(ACT_CONFIG, phase_offsets[p]);
      for (int t = 0; t < 10; t++) tag_pool[t] = $urandom;
      set_base = $urandom_range(NUM_SETS - 1);
      for (int n = 0; n < PHASE_LEN; n++) begin
        if ($urandom_range(9) == 0) begin
          addr = $urandom;
        end else begin
          wide = ({32'b0, tag_pool[$urandom_range(9)]} << (off + SET_BITS))
               | (64'((set_base + $urandom_range(3)) % NUM_SETS) << off)
               | (64'($urandom) & ((64'd1 << off) - 1));
          addr = wide[ADDR_W-1:0];
        end
        add_access(logic'($urandom_range(1)), addr, pct);
        if (p == 2 && n == PHASE_LEN / 2) add_control(ACT_PAUSE, '0);
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (stimulus_q.size() != 0 || start || cfg_we || expected_results.size() != 0
           || quiet_cycles < DRAIN);

    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/salc_pkg.sv
design/salc_ram.sv
design/set_associative_lru_cache.sv
tb/set_associative_lru_cache_test.sv
